/* design/sldpc_pkg.sv */
// ============================================================================
// sldpc_pkg: shared types and constants of the systematic LDPC parity encoder
// Holds the field layout of the stream ports, the register indexes, the
// item kinds and the state type of the encoder sequencer.
// ============================================================================
`default_nettype none

package sldpc_pkg;

    // Fixed field widths.
    localparam int LEN_W      = 11;
    localparam int ROW_FLD_W  = 10;
    localparam int WIDX_FLD_W = 4;
    localparam int WORD_W     = 64;

    // Input tdata layout, from the lowest bit up.
    localparam int S_ROW_LSB  = 0;
    localparam int S_WIDX_LSB = S_ROW_LSB + ROW_FLD_W;
    localparam int S_WORD_LSB = S_WIDX_LSB + WIDX_FLD_W;
    localparam int S_BIT_LSB  = S_WORD_LSB + WORD_W;
    localparam int S_TDATA_W  = ((S_BIT_LSB + 1 + 7) / 8) * 8;

    // Output tdata layout, from the lowest bit up.
    localparam int M_IDX_LSB  = WORD_W;
    localparam int M_TDATA_W  = ((M_IDX_LSB + WIDX_FLD_W + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_INFO_LEN   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARITY_LEN = 8'd1;
    localparam logic [LEN_W-1:0]     LEN_RESET      = 11'd1024;

    // Item kinds carried in tuser.
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_INFO = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_DRAIN,
        ST_EMIT_RD,
        ST_EMIT_LOAD,
        ST_EMIT_HOLD
    } enc_state_t;

endpackage : sldpc_pkg

`default_nettype wire

/* design/sldpc_gen_store.sv */
// ============================================================================
// sldpc_gen_store: generator row store
// Single synchronous memory of 64-bit generator words, addressed by row and
// word. One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module sldpc_gen_store
    import sldpc_pkg::*;
#(
    parameter int ADDR_W = 14
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WORD_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WORD_W-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : sldpc_gen_store

`default_nettype wire

/* design/systematic_ldpc_parity_encoder.sv */
// ============================================================================
// systematic_ldpc_parity_encoder: systematic LDPC encoder, generator form
// Generator parity rows are loaded as 64-bit words into a row store. Each
// info bit that is one XORs its row into a parity accumulator; after
// info_len bits the parity words are sent out, the last one marked.
// ============================================================================
//
//  Channel   Direction  Payload
//  s_*       in         tuser: kind; tdata: gen_row, gen_word_index, gen_word,
//                       info_bit
//  m_*       out        tdata: parity_word, parity_word_index; tlast: last
//  cfg_*     in         cfg_index selects info_len (0) or parity_len (1)
//
// Loads and info bits of zero are taken in ST_IDLE. An info bit of one
// passes through ST_ACC for nwords = ceil(parity_len / 64) words and then
// ST_DRAIN, because the accumulation reads one generator word per cycle
// from the row store. Each parity word then passes ST_EMIT_RD, ST_EMIT_LOAD
// (accumulator read, output register) and waits in ST_EMIT_HOLD on a stall.
// Reset is synchronous and active low and clears the accumulator at once.
// A stalled output holds the block; no input is taken until it drains.
`default_nettype none

module systematic_ldpc_parity_encoder
    import sldpc_pkg::*;
#(
    parameter int MAX_INFO_BITS   = 1024,
    parameter int MAX_PARITY_BITS = 1024
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Input stream.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [9:0] gen_row, [13:10] gen_word_index, [77:14] gen_word,
    // [78] info_bit, [79] zero
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // [0] kind
    input  wire logic [0:0]           s_tuser,
    // Output stream.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [63:0] parity_word, [67:64] parity_word_index, [71:68] zero
    output logic      [M_TDATA_W-1:0] m_tdata,
    output logic                      m_tlast,
    // Configuration writes.
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [LEN_W-1:0]     cfg_data
);

    localparam int PAR_WORDS = (MAX_PARITY_BITS + 63) / 64;
    localparam int WB        = (PAR_WORDS > 1) ? $clog2(PAR_WORDS) : 1;
    localparam int WCW       = $clog2(PAR_WORDS + 1);
    localparam int RB        = $clog2(MAX_INFO_BITS);
    localparam int AW        = RB + WB;

    enc_state_t state_reg, state_next;

    logic [LEN_W-1:0]  info_len_reg;
    logic [LEN_W-1:0]  parity_len_reg;
    logic [LEN_W-1:0]  info_count_reg;
    logic [RB-1:0]     row_reg;
    logic [WCW-1:0]    nwords_reg;
    logic [5:0]        plen_lo_reg;
    logic              emit_pend_reg;
    logic [WCW-1:0]    idx_reg;

    logic              pipe_vld_reg;
    logic [WB-1:0]     pipe_idx_reg;

    logic [WORD_W-1:0] acc_mem [PAR_WORDS];
    logic [PAR_WORDS-1:0] acc_valid_reg;
    logic [WORD_W-1:0] acc_rd_reg;
    logic              acc_rdv_reg;

    logic [WORD_W-1:0] out_word_reg;
    logic [3:0]        out_idx_reg;
    logic              out_last_reg;

    // Input field views.
    logic                  in_kind;
    logic [ROW_FLD_W-1:0]  in_row;
    logic [WIDX_FLD_W-1:0] in_widx;
    logic [WORD_W-1:0]     in_word;
    logic                  in_bit;

    logic        in_xfer;
    logic        info_xfer;
    logic        out_xfer;
    logic [31:0] klen;
    logic [31:0] plen;
    logic [31:0] nwords_full;
    logic [LEN_W-1:0] count_inc;
    logic        reach;
    logic [31:0] row_full;
    logic [31:0] row_eff;
    logic [31:0] load_row_full;
    logic [31:0] load_widx_full;
    logic        load_ok;
    logic [31:0] idx_full;
    logic        idx_is_last;

    logic          gen_we;
    logic [AW-1:0] gen_waddr;
    logic          gen_re;
    logic [AW-1:0] gen_raddr;
    logic [WORD_W-1:0] gen_rdata;

    logic          acc_re;
    logic [WORD_W-1:0] acc_old;
    logic [WORD_W-1:0] last_mask;

    assign in_kind = s_tuser[0];
    assign in_row  = s_tdata[S_ROW_LSB +: ROW_FLD_W];
    assign in_widx = s_tdata[S_WIDX_LSB +: WIDX_FLD_W];
    assign in_word = s_tdata[S_WORD_LSB +: WORD_W];
    assign in_bit  = s_tdata[S_BIT_LSB];

    assign in_xfer   = s_tvalid && s_tready;
    assign info_xfer = in_xfer && (in_kind == KIND_INFO);
    assign out_xfer  = m_tvalid && m_tready;

    // Clamped lengths and the number of parity words.
    always_comb begin
        klen = 32'(info_len_reg);
        if (klen == 32'd0) begin
            klen = 32'd1;
        end else if (klen > 32'(MAX_INFO_BITS)) begin
            klen = 32'(MAX_INFO_BITS);
        end
        plen = 32'(parity_len_reg);
        if (plen == 32'd0) begin
            plen = 32'd1;
        end else if (plen > 32'(MAX_PARITY_BITS)) begin
            plen = 32'(MAX_PARITY_BITS);
        end
        nwords_full = (plen + 32'd63) >> 6;
    end

    // Bit count and the generator row that the current bit uses.
    assign count_inc = info_count_reg + 1'b1;
    assign reach     = 32'(count_inc) >= klen;
    assign row_full  = 32'(info_count_reg);
    assign row_eff   = (row_full >= 32'(MAX_INFO_BITS)) ? 32'(MAX_INFO_BITS - 1) : row_full;

    // Load range check.
    assign load_row_full  = 32'(in_row);
    assign load_widx_full = 32'(in_widx);
    assign load_ok = (load_row_full < 32'(MAX_INFO_BITS)) &&
                     (load_widx_full < 32'(PAR_WORDS));

    assign idx_full    = 32'(idx_reg);
    assign idx_is_last = idx_reg == (nwords_reg - 1'b1);

    // Generator store.
    assign gen_waddr = {load_row_full[RB-1:0], load_widx_full[WB-1:0]};
    assign gen_raddr = {row_reg, idx_reg[WB-1:0]};

    sldpc_gen_store #(
        .ADDR_W (AW)
    ) u_gen_store (
        .aclk    (aclk),
        .wr_en   (gen_we),
        .wr_addr (gen_waddr),
        .wr_data (in_word),
        .rd_en   (gen_re),
        .rd_addr (gen_raddr),
        .rd_data (gen_rdata)
    );

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (info_xfer) begin
                    if (in_bit) begin
                        state_next = ST_ACC;
                    end else if (reach) begin
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            ST_ACC: begin
                if (idx_is_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = emit_pend_reg ? ST_EMIT_RD : ST_IDLE;
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_LOAD;
            end
            ST_EMIT_LOAD: begin
                state_next = ST_EMIT_HOLD;
            end
            ST_EMIT_HOLD: begin
                if (m_tready) begin
                    state_next = out_last_reg ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        gen_re   = 1'b0;
        acc_re   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_ACC: begin
                gen_re = 1'b1;
                acc_re = 1'b1;
            end
            ST_EMIT_RD: begin
                acc_re = 1'b1;
            end
            ST_EMIT_HOLD: begin
                m_tvalid = 1'b1;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign gen_we = in_xfer && (in_kind == KIND_LOAD) && load_ok;

    // State and control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            info_count_reg <= '0;
            info_len_reg   <= LEN_RESET;
            parity_len_reg <= LEN_RESET;
            emit_pend_reg  <= 1'b0;
            idx_reg        <= '0;
            pipe_vld_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pipe_vld_reg <= (state_reg == ST_ACC);

            // Register writes.
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_INFO_LEN:   info_len_reg   <= cfg_data;
                    CFG_PARITY_LEN: parity_len_reg <= cfg_data;
                    default:        info_len_reg   <= info_len_reg;
                endcase
            end

            // Info bit transfer: advance the count, note a pending emission.
            if (info_xfer) begin
                info_count_reg <= reach ? '0 : count_inc;
                emit_pend_reg  <= reach;
                idx_reg        <= '0;
            end

            // Word index through accumulation and emission.
            if (state_reg == ST_ACC) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (state_reg == ST_DRAIN) begin
                idx_reg <= '0;
            end
            if ((state_reg == ST_EMIT_HOLD) && m_tready && !out_last_reg) begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // Per-bit payload registers.
    always_ff @(posedge aclk) begin
        if (info_xfer) begin
            row_reg     <= row_eff[RB-1:0];
            nwords_reg  <= nwords_full[WCW-1:0];
            plen_lo_reg <= plen[5:0];
        end
        pipe_idx_reg <= idx_reg[WB-1:0];
    end

    // Accumulator memory: read, XOR with the generator word, write back.
    assign acc_old = acc_rdv_reg ? acc_rd_reg : '0;

    always_ff @(posedge aclk) begin
        if (pipe_vld_reg) begin
            acc_mem[pipe_idx_reg] <= gen_rdata ^ acc_old;
        end
        if (acc_re) begin
            acc_rd_reg  <= acc_mem[idx_reg[WB-1:0]];
            acc_rdv_reg <= acc_valid_reg[idx_reg[WB-1:0]];
        end
    end

    // Valid bits; an entry that is not valid reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_valid_reg <= '0;
        end else if (out_xfer && out_last_reg) begin
            acc_valid_reg <= '0;
        end else if (pipe_vld_reg) begin
            acc_valid_reg[pipe_idx_reg] <= 1'b1;
        end
    end

    // Output register; the final word is cut off above parity_len.
    always_comb begin
        last_mask = '1;
        if (plen_lo_reg != 6'd0) begin
            last_mask = (64'd1 << plen_lo_reg) - 64'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EMIT_LOAD) begin
            out_word_reg <= idx_is_last ? (acc_old & last_mask) : acc_old;
            out_idx_reg  <= idx_full[3:0];
            out_last_reg <= idx_is_last;
        end
    end

    assign m_tdata   = {{(M_TDATA_W - M_IDX_LSB - WIDX_FLD_W){1'b0}}, out_idx_reg, out_word_reg};
    assign m_tlast   = out_last_reg;
    assign cfg_ready = 1'b1;

endmodule : systematic_ldpc_parity_encoder

`default_nettype wire

/* bench/tb_systematic_ldpc_parity_encoder.sv */
// ============================================================================
// tb_systematic_ldpc_parity_encoder: self-checking bench for the LDPC encoder
// Loads generator rows, streams information bits and compares every parity
// word against an in-bench encoder that tracks the row store, the parity
// accumulator and both length registers. Both stream sides idle at random,
// and lengths are changed between codewords and in the middle of codewords.
// ============================================================================
`timescale 1ns / 1ps

localparam int GEN_ROWS  = 1024;
localparam int PAR_BITS  = 1024;
localparam int ROW_WORDS = (PAR_BITS + 63) / 64;

// One expected parity word as it leaves the result stream.
typedef struct packed {
    logic [sldpc_pkg::WORD_W-1:0]     word;
    logic [sldpc_pkg::WIDX_FLD_W-1:0] index;
    logic                             is_last;
} parity_beat_t;

// Encoder image: generator store, accumulator, bit count and the registers.
class parity_tracker;
    logic [sldpc_pkg::WORD_W-1:0] gen_mem [GEN_ROWS*ROW_WORDS];
    bit                           gen_set [GEN_ROWS*ROW_WORDS];
    logic [sldpc_pkg::WORD_W-1:0] accum [ROW_WORDS];
    logic [sldpc_pkg::LEN_W-1:0]  info_len_reg;
    logic [sldpc_pkg::LEN_W-1:0]  parity_len_reg;
    int unsigned                  bit_count;
    parity_beat_t                 due_words [$];
    int unsigned                  n_errors;
    int unsigned                  n_loads;
    int unsigned                  n_bits;
    int unsigned                  n_codewords;
    int unsigned                  n_words_checked;

    function new();
        foreach (accum[w]) accum[w] = '0;
        info_len_reg   = sldpc_pkg::LEN_RESET;
        parity_len_reg = sldpc_pkg::LEN_RESET;
        bit_count      = 0;
        n_errors       = 0;
        n_loads        = 0;
        n_bits         = 0;
        n_codewords    = 0;
        n_words_checked = 0;
    endfunction

    // Zero counts as one, anything past the maximum as the maximum.
    function int unsigned clamp_len(int unsigned v, int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function int unsigned info_bits();
        return clamp_len(info_len_reg, GEN_ROWS);
    endfunction

    function int unsigned active_words();
        return (clamp_len(parity_len_reg, PAR_BITS) + 63) / 64;
    endfunction

    // True when every word of the row that is used at present has been loaded.
    function bit row_loaded(int unsigned row);
        for (int unsigned w = 0; w < active_words(); w++) begin
            if (!gen_set[row*ROW_WORDS + w]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function void write_reg(logic [sldpc_pkg::CFG_IDX_W-1:0] idx,
                            logic [sldpc_pkg::LEN_W-1:0] val);
        if (idx == sldpc_pkg::CFG_INFO_LEN) info_len_reg = val;
        else if (idx == sldpc_pkg::CFG_PARITY_LEN) parity_len_reg = val;
    endfunction

    // Note an accepted input transfer and queue the parity words it releases.
    function void take_item(logic kind, logic [sldpc_pkg::ROW_FLD_W-1:0] row,
                            logic [sldpc_pkg::WIDX_FLD_W-1:0] widx,
                            logic [sldpc_pkg::WORD_W-1:0] word, logic ibit);
        int unsigned  plen;
        int unsigned  nw;
        int unsigned  top;
        parity_beat_t beat;
        if (kind == sldpc_pkg::KIND_LOAD) begin
            if (row < GEN_ROWS && widx < ROW_WORDS) begin
                gen_mem[row*ROW_WORDS + widx] = word;
                gen_set[row*ROW_WORDS + widx] = 1'b1;
            end
            n_loads++;
            return;
        end
        n_bits++;
        plen = clamp_len(parity_len_reg, PAR_BITS);
        nw   = active_words();
        if (ibit) begin
            for (int unsigned w = 0; w < nw; w++)
                accum[w] ^= gen_mem[bit_count*ROW_WORDS + w];
        end
        bit_count++;
        if (bit_count < info_bits()) return;
        for (int unsigned k = 0; k < nw; k++) begin
            beat.word = accum[k];
            top = plen - k*64;
            if (top < 64) beat.word &= (64'd1 << top) - 64'd1;
            beat.index   = k[sldpc_pkg::WIDX_FLD_W-1:0];
            beat.is_last = (k == nw - 1);
            due_words.push_back(beat);
        end
        foreach (accum[w]) accum[w] = '0;
        bit_count = 0;
        n_codewords++;
    endfunction

    // Compare one accepted result transfer with the oldest expected word.
    function void check_word(logic [sldpc_pkg::WORD_W-1:0] word,
                             logic [sldpc_pkg::WIDX_FLD_W-1:0] index, logic is_last);
        parity_beat_t exp_beat;
        if (due_words.size() == 0) begin
            $error("parity word with no codeword pending: word %h, index %0d, last %0b",
                   word, index, is_last);
            n_errors++;
            return;
        end
        exp_beat = due_words.pop_front();
        n_words_checked++;
        if (word !== exp_beat.word) begin
            $error("parity_word mismatch: expected %h, actual %h", exp_beat.word, word);
            n_errors++;
        end
        if (index !== exp_beat.index) begin
            $error("parity_word_index mismatch: expected %0d, actual %0d",
                   exp_beat.index, index);
            n_errors++;
        end
        if (is_last !== exp_beat.is_last) begin
            $error("last mismatch: expected %0b, actual %0b", exp_beat.is_last, is_last);
            n_errors++;
        end
    endfunction
endclass

module tb_systematic_ldpc_parity_encoder;
    import sldpc_pkg::*;

    localparam int HALF_PERIOD    = 2;
    localparam int MAX_GAP        = 14;
    localparam int HOLD_OFF       = 32;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 300;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = '1;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [0:0]           s_tuser   = '0;
    logic                 m_tready  = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LEN_W-1:0]     cfg_data  = '0;
    wire                  s_tready;
    wire                  m_tvalid;
    wire  [M_TDATA_W-1:0] m_tdata;
    wire                  m_tlast;
    wire                  cfg_ready;

    parity_tracker tracker = new();
    bit            tx_steady = 1'b0;
    bit            rx_steady = 1'b0;
    int unsigned   items_sent = 0;
    int unsigned   reg_writes = 0;
    int unsigned   idle_cycles = 0;

    systematic_ldpc_parity_encoder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Stop the run when no channel has moved a transfer for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("systematic_ldpc_parity_encoder test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: random stall before each word, then check it.
    initial begin : result_sink
        int unsigned stall;
        wait (aresetn);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(MAX_GAP, 0);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            tracker.check_word(m_tdata[WORD_W-1:0], m_tdata[M_IDX_LSB +: WIDX_FLD_W], m_tlast);
        end
    end

    // Generator words lean toward all zeros and all ones now and then.
    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(7, 0))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // One input transfer; valid stays high when the next item follows at once.
    task automatic send_item(input logic kind, input logic [ROW_FLD_W-1:0] row,
                             input logic [WIDX_FLD_W-1:0] widx,
                             input logic [WORD_W-1:0] word, input logic ibit);
        int unsigned          gap;
        logic [S_TDATA_W-1:0] data;
        gap  = tx_steady ? 0 : $urandom_range(MAX_GAP, 0);
        data = '0;
        data[S_ROW_LSB +: ROW_FLD_W]   = row;
        data[S_WIDX_LSB +: WIDX_FLD_W] = widx;
        data[S_WORD_LSB +: WORD_W]     = word;
        data[S_BIT_LSB]                = ibit;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tuser  <= kind;
        s_tdata  <= data;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        tracker.take_item(kind, row, widx, word, ibit);
        items_sent++;
    endtask

    // An info bit of one only where its row is loaded; other fields are noise.
    task automatic send_info(input logic want_one);
        logic ibit;
        ibit = want_one && tracker.row_loaded(tracker.bit_count);
        send_item(KIND_INFO, ROW_FLD_W'($urandom), WIDX_FLD_W'($urandom), rand_word(), ibit);
    endtask

    // Load the used words of a range of rows, reloading some that are present.
    task automatic load_rows(input int unsigned first, input int unsigned count);
        for (int unsigned r = first; r < first + count; r++) begin
            for (int unsigned w = 0; w < tracker.active_words(); w++) begin
                if (!tracker.gen_set[r*ROW_WORDS + w] || $urandom_range(3, 0) == 0)
                    send_item(KIND_LOAD, r[ROW_FLD_W-1:0], w[WIDX_FLD_W-1:0], rand_word(),
                              1'($urandom));
            end
        end
    endtask

    // Hold the sender until every expected word is out and the block is quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (tracker.due_words.size() != 0) @(posedge aclk);
        repeat (HOLD_OFF) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
        settle();
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tracker.write_reg(idx, val);
        reg_writes++;
    endtask

    // A few codewords under one random setting, with noise loads and
    // occasional length changes while a codeword is half done.
    task automatic run_phase();
        int unsigned      n_cw;
        logic [LEN_W-1:0] ilen;
        logic [LEN_W-1:0] plen;
        tx_steady = ($urandom_range(3, 0) == 0);
        rx_steady = ($urandom_range(3, 0) == 0);
        ilen = ($urandom_range(9, 0) == 0) ? '0 : LEN_W'($urandom_range(12, 1));
        case ($urandom_range(15, 0))
            0:       plen = '0;
            1:       plen = LEN_W'(PAR_BITS);
            2:       plen = LEN_W'($urandom_range(2047, PAR_BITS + 1));
            3:       plen = LEN_W'($urandom_range(PAR_BITS - 1, 193));
            default: plen = LEN_W'($urandom_range(192, 1));
        endcase
        if ($urandom_range(1, 0)) begin
            write_reg(CFG_INFO_LEN, ilen);
            write_reg(CFG_PARITY_LEN, plen);
        end else begin
            write_reg(CFG_PARITY_LEN, plen);
            write_reg(CFG_INFO_LEN, ilen);
        end
        if ($urandom_range(3, 0) == 0)
            write_reg(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, CFG_PARITY_LEN + 1)),
                      LEN_W'($urandom));
        n_cw = $urandom_range(3, 1);
        repeat (n_cw) begin
            load_rows(0, tracker.info_bits());
            repeat ($urandom_range(2, 0))
                send_item(KIND_LOAD, ROW_FLD_W'($urandom), WIDX_FLD_W'($urandom),
                          rand_word(), 1'($urandom));
            do begin
                if ($urandom_range(9, 0) == 0)
                    send_item(KIND_LOAD, ROW_FLD_W'($urandom), WIDX_FLD_W'($urandom),
                              rand_word(), 1'($urandom));
                if (tracker.bit_count != 0 && $urandom_range(11, 0) == 0) begin
                    if ($urandom_range(1, 0))
                        write_reg(CFG_INFO_LEN, LEN_W'($urandom_range(12, 1)));
                    else
                        write_reg(CFG_PARITY_LEN, LEN_W'($urandom_range(192, 1)));
                end
                send_info(1'($urandom));
            end while (tracker.bit_count != 0);
        end
    endtask

    initial begin : stimulus
        int unsigned base;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Shortest codeword: one info bit, one parity bit.
        write_reg(CFG_INFO_LEN, LEN_W'(1));
        write_reg(CFG_PARITY_LEN, LEN_W'(1));
        send_item(KIND_LOAD, '0, '0, '1, 1'b1);
        send_item(KIND_LOAD, '1, '1, '1, 1'b0);
        send_item(KIND_INFO, '1, '1, '1, 1'b1);
        send_item(KIND_INFO, '0, '0, '0, 1'b0);

        // Zero lengths behave as one.
        write_reg(CFG_INFO_LEN, '0);
        write_reg(CFG_PARITY_LEN, '0);
        send_info(1'b1);

        // Widest parity, over-range length clamps to the maximum; stray index.
        write_reg(CFG_INFO_LEN, LEN_W'(1));
        write_reg(CFG_PARITY_LEN, '1);
        write_reg(CFG_UNMAPPED, LEN_W'($urandom));
        for (int unsigned w = 0; w < ROW_WORDS; w++)
            send_item(KIND_LOAD, '0, w[WIDX_FLD_W-1:0], w[0] ? rand_word() : '1, 1'($urandom));
        send_info(1'b1);

        // Shrink info_len below the bits already taken: next bit closes the codeword.
        write_reg(CFG_PARITY_LEN, LEN_W'(64));
        write_reg(CFG_INFO_LEN, LEN_W'(3));
        send_info(1'b1);
        send_info(1'b1);
        write_reg(CFG_INFO_LEN, LEN_W'(1));
        send_info(1'b1);

        // A longer codeword sent back to back.
        tx_steady = 1'b1;
        write_reg(CFG_INFO_LEN, LEN_W'(16));
        write_reg(CFG_PARITY_LEN, LEN_W'($urandom_range(130, 1)));
        load_rows(0, 16);
        do send_info(1'($urandom)); while (tracker.bit_count != 0);

        // Random phases.
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) run_phase();

        tx_steady = 1'b0;
        settle();
        $display("Ran %0d input transfers: %0d generator loads and %0d info bits, %0d writes.",
                 items_sent, tracker.n_loads, tracker.n_bits, reg_writes);
        $display("Checked %0d parity words from %0d codewords, %0d mismatches.",
                 tracker.n_words_checked, tracker.n_codewords, tracker.n_errors);
        if (tracker.n_errors == 0)
            $display("systematic_ldpc_parity_encoder test passed");
        else
            $display("systematic_ldpc_parity_encoder test failed");
        $finish;
    end
endmodule

/* sim.f */
design/sldpc_pkg.sv
design/sldpc_gen_store.sv
design/systematic_ldpc_parity_encoder.sv
bench/tb_systematic_ldpc_parity_encoder.sv
